// File: design/software_timer_table_macros.svh
// Assertion macros for the software timer table.
// Included by the top level; no other dependencies.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define STT_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define STT_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STT_ASSERT_RST(label, clk, rst, prop, msg)
`define STT_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

// File: design/stt_pkg.sv
// Shared types and constants of the software timer table.
// No dependencies.
`default_nettype none

package stt_pkg;

   localparam int HZ_W     = 20;
   localparam int TICKS_W  = 32;
   localparam int PROD_W   = 52;
   localparam int REM_W    = 10;
   localparam int DIV_BITS = 4;
   localparam int STEP_W   = 4;

   localparam logic [HZ_W-1:0]     HZ_RESET   = 20'd1000;
   localparam logic [REM_W:0]      MS_PER_SEC = 11'd1000;
   localparam logic [STEP_W-1:0]   DIV_LAST   = 4'd12;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK   = 2'd0;
   localparam cmd_type CMD_ADD    = 2'd1;
   localparam cmd_type CMD_CANCEL = 2'd2;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_EXPIRED   = 3'd0;
   localparam kind_type KIND_ADDED     = 3'd1;
   localparam kind_type KIND_FULL      = 3'd2;
   localparam kind_type KIND_CANCELLED = 3'd3;
   localparam kind_type KIND_NOT_FOUND = 3'd4;
   localparam kind_type KIND_TICK_DONE = 3'd5;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] expire_ms;
      logic [31:0] reload_ms;
      logic [31:0] cancel_id;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] handle;
      logic [63:0] tick_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic               live;
      logic [TICKS_W-1:0] remaining;
      logic [TICKS_W-1:0] reload;
      logic [31:0]        id;
   } slot_type;

endpackage

`default_nettype wire

// File: design/stt_conv.sv
// Millisecond to tick converter: registered multiply, then radix-16 division by 1000.
// Depends on stt_pkg.
`default_nettype none

module stt_conv
   import stt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [HZ_W-1:0]    hz,
   input  wire logic [31:0]        ms,
   output logic                    done,
   output logic [TICKS_W-1:0]      ticks
);

   logic [PROD_W-1:0] work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [REM_W:0]    rem_ext;

   // Shift four dividend bits into the remainder per cycle; quotient bits fill from below.
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_ext = '0;
      if (start) begin
         work_in = PROD_W'(hz) * PROD_W'(ms);
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         for (int j = 0; j < DIV_BITS; j++) begin
            rem_ext = {rem_in, work_in[PROD_W-1]};
            work_in = {work_in[PROD_W-2:0], 1'b0};
            if (rem_ext >= MS_PER_SEC) begin
               rem_ext    = rem_ext - MS_PER_SEC;
               work_in[0] = 1'b1;
            end
            rem_in = rem_ext[REM_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done  = done_ff;
   // Saturate to 32 bits.
   assign ticks = (|work_ff[PROD_W-1:TICKS_W]) ? '1 : work_ff[TICKS_W-1:0];

endmodule

`default_nettype wire

// File: design/stt_cell.sv
// One timer slot of the rotating slot ring.
// Depends on stt_pkg.
`default_nettype none

module stt_cell
   import stt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     shift,
   input  wire slot_type d_in,
   output slot_type      q
);

   logic               live_ff;
   logic [TICKS_W-1:0] remaining_ff;
   logic [TICKS_W-1:0] reload_ff;
   logic [31:0]        id_ff;

   // Take the neighbor's slot on every shift; only the live bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else if (shift) begin
         live_ff <= d_in.live;
      end
      if (shift) begin
         remaining_ff <= d_in.remaining;
         reload_ff    <= d_in.reload;
         id_ff        <= d_in.id;
      end
   end

   assign q = '{live: live_ff, remaining: remaining_ff, reload: reload_ff, id: id_ff};

endmodule

`default_nettype wire

// File: design/software_timer_table.sv
// Software timer table top level: command sequencer, slot ring and converters.
// Depends on stt_pkg, stt_cell, stt_conv and software_timer_table_macros.svh.
//
//   channel   ports                         handshake
//   request   start, busy, req              taken when start is high and busy low
//   result    rsp_valid, rsp                one cycle per result, cannot be held off
//   config    csr_write_en, csr_write_data  written on any edge with the enable high
//
// Sequence: a tick or a cancel goes from idle through the walk and the done state; an
// add first waits in the conversion state for the millisecond converters (thirteen radix-16
// steps of the divide by 1000, then done is raised; the multiply is registered at
// the accepting edge). During the walk one slot reaches the head each cycle.
// A request with an unknown command leaves busy low.
// Reset clears all live bits, the tick count, the id counter and sets tick_hz to 1000.
// Results come out registered, from the walk's slots and from the done state; the receiver cannot stall.
`default_nettype none

`include "software_timer_table_macros.svh"

module software_timer_table
   import stt_pkg::*;
#(
   parameter int NUM_TIMERS = 16
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire req_type         req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  wire logic            csr_write_en,
   input  wire logic [HZ_W-1:0] csr_write_data
);

   localparam int CNT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TIMERS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [HZ_W-1:0]    tick_hz_ff, tick_hz_in;
   logic [63:0]        total_ticks_ff, total_ticks_in;
   logic [31:0]        next_id_ff, next_id_in;
   cmd_type            cmd_ff, cmd_in;
   logic [31:0]        cancel_id_ff, cancel_id_in;
   logic [31:0]        hit_id_ff, hit_id_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff, kind_in;
   logic [31:0]        rsp_id_ff, rsp_id_in;
   logic               last_ff, last_in;

   logic               accept;
   logic               conv_start;
   logic               exp_done, rel_done;
   logic [TICKS_W-1:0] exp_ticks, rel_ticks;
   logic               shift;
   slot_type           head, head_new;
   logic               emit_expired;
   slot_type           cell_q [NUM_TIMERS];

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign conv_start = accept && (req.cmd == CMD_ADD);
   assign shift      = (state_ff == ST_WALK);

   // Both converters start together and finish on the same cycle.
   stt_conv u_conv_expire (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .hz    (tick_hz_ff),
      .ms    (req.expire_ms),
      .done  (exp_done),
      .ticks (exp_ticks)
   );

   stt_conv u_conv_reload (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .hz    (tick_hz_ff),
      .ms    (req.reload_ms),
      .done  (rel_done),
      .ticks (rel_ticks)
   );

   // Slot ring: each cell takes its upper neighbor; the head, after processing, wraps
   // to the tail. After NUM_TIMERS shifts every slot is back in place, and the head
   // has seen the slots in ascending order.
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      slot_type d_next;
      if (i == NUM_TIMERS - 1) begin : g_tail
         assign d_next = head_new;
      end else begin : g_mid
         assign d_next = cell_q[i+1];
      end
      stt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d_in  (d_next),
         .q     (cell_q[i])
      );
   end

   assign head = cell_q[0];

   // Process the slot at the head of the ring.
   always_comb begin
      head_new     = head;
      found_in     = found_ff;
      next_id_in   = next_id_ff;
      hit_id_in    = hit_id_ff;
      emit_expired = 1'b0;
      case (cmd_ff)
         CMD_TICK: begin
            if (head.live) begin
               if (head.remaining <= TICKS_W'(1)) begin
                  // Due: restart from the reload count, or drop a one-shot timer.
                  emit_expired = 1'b1;
                  if (head.reload != '0) begin
                     head_new.remaining = head.reload;
                  end else begin
                     head_new.live = 1'b0;
                  end
               end else begin
                  head_new.remaining = head.remaining - 1'b1;
               end
            end
         end
         CMD_ADD: begin
            // Claim the first free slot.
            if (!found_ff && !head.live) begin
               head_new.live      = 1'b1;
               head_new.remaining = exp_ticks;
               head_new.reload    = rel_ticks;
               head_new.id        = next_id_ff;
               found_in           = 1'b1;
               hit_id_in          = next_id_ff;
               next_id_in         = next_id_ff + 1'b1;
            end
         end
         CMD_CANCEL: begin
            // Free the first live slot holding the id.
            if (!found_ff && head.live && (head.id == cancel_id_ff)) begin
               head_new.live = 1'b0;
               found_in      = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!shift) begin
         found_in   = found_ff;
         next_id_in = next_id_ff;
         hit_id_in  = hit_id_ff;
      end
   end

   // Sequencer and result register.
   always_comb begin
      state_in       = state_ff;
      tick_hz_in     = csr_write_en ? csr_write_data : tick_hz_ff;
      total_ticks_in = total_ticks_ff;
      cmd_in         = cmd_ff;
      cancel_id_in   = cancel_id_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      kind_in        = kind_ff;
      rsp_id_in      = rsp_id_ff;
      last_in        = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in       = req.cmd;
               cancel_id_in = req.cancel_id;
               cnt_in       = '0;
               case (req.cmd)
                  CMD_TICK: begin
                     total_ticks_in = total_ticks_ff + 64'd1;
                     state_in       = ST_WALK;
                  end
                  CMD_ADD: begin
                     state_in = ST_CONV;
                  end
                  CMD_CANCEL: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CONV: begin
            if (exp_done && rel_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + 1'b1;
            if (emit_expired) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_EXPIRED;
               rsp_id_in    = head.id;
               last_in      = 1'b0;
            end
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            last_in      = 1'b1;
            case (cmd_ff)
               CMD_ADD: begin
                  kind_in   = found_ff ? KIND_ADDED : KIND_FULL;
                  rsp_id_in = found_ff ? hit_id_ff : 32'd0;
               end
               CMD_CANCEL: begin
                  kind_in   = found_ff ? KIND_CANCELLED : KIND_NOT_FOUND;
                  rsp_id_in = cancel_id_ff;
               end
               default: begin
                  kind_in   = KIND_TICK_DONE;
                  rsp_id_in = 32'd0;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_hz_ff     <= HZ_RESET;
         total_ticks_ff <= '0;
         next_id_ff     <= '0;
         found_ff       <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tick_hz_ff     <= tick_hz_in;
         total_ticks_ff <= total_ticks_in;
         next_id_ff     <= next_id_in;
         found_ff       <= accept ? 1'b0 : found_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      cancel_id_ff <= cancel_id_in;
      hit_id_ff    <= hit_id_in;
      kind_ff      <= kind_in;
      rsp_id_ff    <= rsp_id_in;
      last_ff      <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = '{kind: kind_ff, handle: rsp_id_ff, tick_count: total_ticks_ff,
                        last: last_ff};

   // Expiry results only come out while the block is busy.
   `STT_ASSERT_RST(a_expired_while_busy, clock, reset, ((rsp_valid && !rsp.last) |-> busy), "expiry result outside walk")
   // The two converters stay in lock step.
   `STT_ASSERT_RST(a_conv_lockstep, clock, reset, (exp_done == rel_done), "converters out of step")
   // An accepted tick raises the tick count by exactly one and starts the walk.
   `STT_ASSERT_RST(a_tick_count, clock, reset, ((accept && (req.cmd == CMD_TICK)) |=> (busy && (total_ticks_ff == $past(total_ticks_ff) + 64'd1))), "tick count not advanced")

endmodule

`default_nettype wire

// File: tb/tb_software_timer_table.sv
// Self-checking testbench for the software timer table: random and directed requests
// against a cycle-free predictor of the timer slots. Depends on stt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_software_timer_table;
   import stt_pkg::*;

   localparam int TIMER_SLOTS = 16;
   // Allow for the longest request (an add) plus the trailing result.
   localparam int SETTLE_CYCLES = TIMER_SLOTS + 24;
   localparam int RUN_LIMIT = 800_000;
   localparam int PHASE_REQUESTS = 85;
   localparam cmd_type CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req = '0;
   logic rsp_valid;
   rsp_type rsp;
   logic csr_write_en = 1'b0;
   logic [HZ_W-1:0] csr_write_data = HZ_RESET;

   software_timer_table #(.NUM_TIMERS(TIMER_SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp(rsp),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Predicted copy of the timer table. Slot fields are read only while armed.
   bit               slot_armed [TIMER_SLOTS];
   bit [31:0]        slot_left [TIMER_SLOTS];
   bit [31:0]        slot_period [TIMER_SLOTS];
   bit [31:0]        slot_tag [TIMER_SLOTS];
   bit [63:0]        ticks_seen = '0;
   bit [31:0]        id_counter = '0;
   logic [HZ_W-1:0]  hz_setting = HZ_RESET;

   req_type     queued_requests[$];
   rsp_type     awaited_results[$];
   int unsigned mismatch_count = 0;
   int unsigned gap_left = 0;
   int unsigned cycle_count = 0;
   bit          steady_flow = 1'b0;
   logic [31:0] adds_queued = '0;

   // Convert milliseconds to ticks at the current rate; clamp to 32 bits.
   function automatic logic [31:0] ms_to_ticks(logic [31:0] ms);
      logic [63:0] scaled;
      scaled = (64'(hz_setting) * 64'(ms)) / 64'(MS_PER_SEC);
      return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
   endfunction

   function automatic void expect_result(kind_type kind, logic [31:0] id, logic last);
      rsp_type r;
      r.kind = kind;
      r.handle = id;
      r.tick_count = ticks_seen;
      r.last = last;
      awaited_results.push_back(r);
   endfunction

   // Apply one accepted request to the predicted table and queue its results.
   function automatic void apply_request(req_type r);
      int s;
      bit placed;
      placed = 1'b0;
      case (r.cmd)
         CMD_TICK: begin
            ticks_seen++;
            // Walk ascending; a count of 0 or 1 falls due on this tick.
            for (s = 0; s < TIMER_SLOTS; s++) begin
               if (slot_armed[s]) begin
                  if (slot_left[s] <= 32'd1) begin
                     expect_result(KIND_EXPIRED, slot_tag[s], 1'b0);
                     if (slot_period[s] != 0) slot_left[s] = slot_period[s];
                     else slot_armed[s] = 1'b0;
                  end else begin
                     slot_left[s]--;
                  end
               end
            end
            expect_result(KIND_TICK_DONE, 32'd0, 1'b1);
         end
         CMD_ADD: begin
            // Take the lowest free slot; a full table consumes no id.
            for (s = 0; s < TIMER_SLOTS && !placed; s++) begin
               if (!slot_armed[s]) begin
                  slot_armed[s] = 1'b1;
                  slot_left[s] = ms_to_ticks(r.expire_ms);
                  slot_period[s] = ms_to_ticks(r.reload_ms);
                  slot_tag[s] = id_counter;
                  expect_result(KIND_ADDED, id_counter, 1'b1);
                  id_counter++;
                  placed = 1'b1;
               end
            end
            if (!placed) expect_result(KIND_FULL, 32'd0, 1'b1);
         end
         CMD_CANCEL: begin
            for (s = 0; s < TIMER_SLOTS && !placed; s++) begin
               if (slot_armed[s] && slot_tag[s] == r.cancel_id) begin
                  slot_armed[s] = 1'b0;
                  placed = 1'b1;
               end
            end
            expect_result(placed ? KIND_CANCELLED : KIND_NOT_FOUND, r.cancel_id, 1'b1);
         end
         default: ; // unknown command: no state change, no results
      endcase
   endfunction

   // Idle gaps: mostly short, a few long, none while steady flow is on.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 5);
      if (roll < 97) return $urandom_range(6, 30);
      return $urandom_range(31, 200);
   endfunction

   // Driver: present the next queued request once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (start) apply_request(req);
         if (gap_left != 0 || queued_requests.size() == 0) begin
            start <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            start <= 1'b1;
            req <= queued_requests[0];
            queued_requests.delete(0);
            gap_left <= pick_gap();
         end
      end
   end

   task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
   endtask

   // Monitor: results cannot be held off, so check each one on the edge ending its cycle.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $display("%0t unexpected result: expected none actual %p", $time, rsp);
            mismatch_count++;
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            if (rsp.kind !== want.kind) flag_field("kind", 64'(want.kind), 64'(rsp.kind));
            if (rsp.handle !== want.handle)
               flag_field("handle", 64'(want.handle), 64'(rsp.handle));
            if (rsp.tick_count !== want.tick_count)
               flag_field("tick_count", want.tick_count, rsp.tick_count);
            if (rsp.last !== want.last) flag_field("last", 64'(want.last), 64'(rsp.last));
         end
      end
   end

   function automatic req_type make_request(cmd_type cmd, logic [31:0] expire_ms,
                                            logic [31:0] reload_ms, logic [31:0] cancel_id);
      req_type r;
      r.cmd = cmd;
      r.expire_ms = expire_ms;
      r.reload_ms = reload_ms;
      r.cancel_id = cancel_id;
      return r;
   endfunction

   // Pick milliseconds that land near a small tick count at the current rate,
   // with an occasional full-range value to reach saturation.
   function automatic logic [31:0] pick_ms();
      int unsigned target;
      if ($urandom_range(0, 9) == 0) return $urandom;
      target = $urandom_range(0, 12);
      return (target * 1000 + $urandom_range(0, 999)) / 32'(hz_setting);
   endfunction

   // Mostly well-formed traffic: ticks, adds with short counts, cancels of recent ids;
   // the rest is random ids and unknown commands. Unused fields carry noise.
   task automatic queue_random_requests(int unsigned count);
      int unsigned n;
      int unsigned roll;
      logic [31:0] id;
      logic [31:0] period;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            queued_requests.push_back(make_request(CMD_TICK, $urandom, $urandom, $urandom));
         end else if (roll < 72) begin
            period = ($urandom_range(0, 9) < 4) ? 32'd0 : pick_ms();
            queued_requests.push_back(make_request(CMD_ADD, pick_ms(), period, $urandom));
            adds_queued++;
         end else if (roll < 94) begin
            if ($urandom_range(0, 3) == 0) id = $urandom;
            else id = adds_queued - $urandom_range(1, 16);
            queued_requests.push_back(make_request(CMD_CANCEL, $urandom, $urandom, id));
         end else begin
            queued_requests.push_back(make_request(CMD_UNUSED, $urandom, $urandom, $urandom));
         end
      end
   endtask

   // Hold until every request is taken and every result is in, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      while (queued_requests.size() != 0 || start || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tick rate while idle; the predictor follows at once.
   task automatic write_tick_rate(logic [HZ_W-1:0] hz);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= hz;
      hz_setting = hz;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : run_limit
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int unsigned k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset rate of 1000 Hz (one tick per millisecond).
      queued_requests.push_back(make_request(CMD_TICK, '0, '0, '0));          // empty table
      queued_requests.push_back(make_request(CMD_ADD, 32'd0, 32'd0, '0));     // zero expiry
      queued_requests.push_back(make_request(CMD_ADD, 32'd1, 32'd2, '1));     // reloading
      queued_requests.push_back(make_request(CMD_ADD, 32'd2, 32'd0, '0));     // one-shot
      queued_requests.push_back(make_request(CMD_ADD, '1, '1, '1));           // longest count
      queued_requests.push_back(make_request(CMD_TICK, '1, '1, '1));
      queued_requests.push_back(make_request(CMD_TICK, '0, '0, '0));
      queued_requests.push_back(make_request(CMD_TICK, '0, '0, '0));
      queued_requests.push_back(make_request(CMD_CANCEL, '0, '0, 32'd3));     // found
      queued_requests.push_back(make_request(CMD_CANCEL, '0, '0, 32'd3));     // already gone
      queued_requests.push_back(make_request(CMD_CANCEL, '1, '1, '1));        // never issued
      queued_requests.push_back(make_request(CMD_UNUSED, '1, '1, '1));
      queued_requests.push_back(make_request(CMD_UNUSED, '0, '0, '0));
      queued_requests.push_back(make_request(CMD_CANCEL, '0, '0, 32'd1));     // reloading one
      adds_queued = 32'd4;
      queue_random_requests(PHASE_REQUESTS);
      wait_drained();

      // Slowest rate: short reloads collapse to one-shot. Run without idle gaps.
      steady_flow = 1'b1;
      write_tick_rate(20'd1);
      queue_random_requests(PHASE_REQUESTS);
      wait_drained();
      steady_flow = 1'b0;

      write_tick_rate(HZ_W'($urandom_range(2, 999_999)));
      queue_random_requests(PHASE_REQUESTS);
      wait_drained();

      // Fastest rate: short picks round down to zero milliseconds; full-range picks saturate the count.
      write_tick_rate(20'd1_000_000);
      queue_random_requests(PHASE_REQUESTS);
      // Drop the recent ids so that later phases see expiries again.
      for (k = 1; k <= 48; k++)
         queued_requests.push_back(make_request(CMD_CANCEL, $urandom, $urandom, adds_queued - k));
      wait_drained();

      write_tick_rate(HZ_RESET);
      queue_random_requests(PHASE_REQUESTS);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
